// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the level meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/alapm_pkg.sv =====
// Shared types and constants of the audio level meter.
package alapm_pkg;

    localparam int SAMPLE_W = 12;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Peak tracker result for one transfer.
    typedef struct packed {
        sample_t p2p;
        logic    done;
        logic    empty;
    } peak_t;

endpackage

// ===== hw/rtl/alapm_ring.sv =====
// Sample history ring with per-entry valid bits and prefetched read of the oldest entry.
`include "assert_macros.svh"

module alapm_ring #(
    parameter int DEPTH = 50
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  alapm_pkg::sample_t wr_data,
    output alapm_pkg::sample_t old_data
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

    alapm_pkg::sample_t hist_reg [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [SLOT_W-1:0]  rd_addr;
    alapm_pkg::sample_t rd_data_reg;
    logic               rd_valid_reg;

    assign slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
    // keep the entry at the current slot in the read register
    assign rd_addr   = wr_en ? slot_next : slot_reg;
    assign old_data  = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_reg[slot_reg] <= wr_data;
        end
        rd_data_reg <= hist_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            slot_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[slot_reg] <= 1'b1;
                slot_reg            <= slot_next;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    `ASSERT_IMPL(a_slot_range, aclk, aresetn, 1'b1, slot_reg <= LAST_SLOT)
    `ASSERT_NEXT(a_wr_marks_valid, aclk, aresetn, wr_en, valid_reg[$past(slot_reg)])

endmodule

// ===== hw/rtl/alapm_peak.sv =====
// Window max/min tracker and peak-to-peak result.
`include "assert_macros.svh"

module alapm_peak (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  alapm_pkg::sample_t sample,
    input  logic               last,
    input  alapm_pkg::sample_t reject_level,
    output alapm_pkg::peak_t   peak
);

    alapm_pkg::sample_t max_reg;
    alapm_pkg::sample_t min_reg;
    alapm_pkg::sample_t max_next;
    alapm_pkg::sample_t min_next;

    // else-if rule: a new max is never checked against the min
    always_comb begin
        max_next = max_reg;
        min_next = min_reg;
        if (sample < reject_level) begin
            if (sample > max_reg) begin
                max_next = sample;
            end else if (sample < min_reg) begin
                min_next = sample;
            end
        end
    end

    always_comb begin
        peak = '0;
        if (last) begin
            peak.done = 1'b1;
            if (min_next > max_next) begin
                peak.empty = 1'b1;
            end else begin
                peak.p2p = max_next - min_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= '0;
            min_reg <= alapm_pkg::FULL_SCALE;
        end else if (en) begin
            if (last) begin
                max_reg <= '0;
                min_reg <= alapm_pkg::FULL_SCALE;
            end else begin
                max_reg <= max_next;
                min_reg <= min_next;
            end
        end
    end

    `ASSERT_NEXT(a_window_restart, aclk, aresetn, en && last,
                 max_reg == '0 && min_reg == alapm_pkg::FULL_SCALE)
    `ASSERT_IMPL(a_empty_clamped, aclk, aresetn, peak.empty, peak.done && peak.p2p == '0)

endmodule

// ===== hw/rtl/alapm_avg.sv =====
// Floored mean: running sum divided by the ring depth via reciprocal multiply.
module alapm_avg #(
    parameter int DEPTH = 50,
    parameter int SUM_W = 18
) (
    input  logic [SUM_W-1:0]   sum,
    output alapm_pkg::sample_t average
);

    localparam int L_W     = $clog2(DEPTH);
    localparam int K       = SUM_W + L_W;
    localparam int RECIP_W = K + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^K / DEPTH); exact floor for every SUM_W-bit numerator
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << K) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

    logic [PROD_W-1:0] prod;

    assign prod    = PROD_W'(sum) * PROD_W'(RECIP);
    assign average = prod[K +: alapm_pkg::SAMPLE_W];

endmodule

// ===== hw/rtl/audio_level_average_peak_meter_top.sv =====
// Top level of the audio level meter: moving average and windowed peak-to-peak.
//
// One 12-bit sample is taken per clock while the output is not stalled, and
// one result leaves per sample, through the stage-1 register and then the
// output register. The ring of the last DEPTH samples lives in a one-write,
// one-read memory whose read port always holds the entry about to be
// overwritten, so the running-sum update (minus oldest, plus new) completes in
// the transfer cycle; between the stage-1 sum and the output register the sum
// is divided by DEPTH with a reciprocal multiply. Every ring entry has a valid
// bit cleared by reset, so no clearing pass is needed. Peak tracking ignores
// samples at or above reject_level, which is written through the cfg port
// (always ready) and should only change while the block is idle. A sample flagged
// window_last closes the window: its result carries window_done, max minus min,
// and window_empty when min ended above max (peak_to_peak then reads zero).
`include "assert_macros.svh"

module audio_level_average_peak_meter_top #(
    parameter int DEPTH = 50
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  alapm_pkg::sample_t  cfg_data,
    // sample input
    input  logic                s_valid,
    output logic                s_ready,
    input  alapm_pkg::sample_t  s_sample,
    input  logic                s_window_last,
    // results
    output logic                m_valid,
    input  logic                m_ready,
    output alapm_pkg::sample_t  m_average,
    output alapm_pkg::sample_t  m_peak_to_peak,
    output logic                m_window_done,
    output logic                m_window_empty
);

    localparam int SUM_W = $clog2(DEPTH * int'(alapm_pkg::FULL_SCALE) + 1);
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(DEPTH * int'(alapm_pkg::FULL_SCALE));

    alapm_pkg::sample_t reject_reg;

    logic               in_xfer;
    logic               s1_adv;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               m_valid_reg;
    logic               m_valid_next;

    alapm_pkg::sample_t old_sample;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    alapm_pkg::peak_t   peak;
    alapm_pkg::peak_t   s1_peak_reg;
    alapm_pkg::sample_t avg;

    alapm_pkg::sample_t m_average_reg;
    alapm_pkg::peak_t   m_peak_reg;

    // configuration register, write accepted every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reject_reg <= alapm_pkg::FULL_SCALE;
        end else if (cfg_valid) begin
            reject_reg <= cfg_data;
        end
    end

    // two-stage pipeline control: stage 1 holds the new sum and peak result,
    // the output register holds the finished result
    assign s1_adv        = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready       = !s1_valid_reg || s1_adv;
    assign in_xfer       = s_valid && s_ready;
    assign s1_valid_next = in_xfer || (s1_valid_reg && !s1_adv);
    assign m_valid_next  = s1_adv || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            sum_reg      <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (in_xfer) begin
                sum_reg <= sum_next;
            end
        end
    end

    alapm_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (in_xfer),
        .wr_data  (s_sample),
        .old_data (old_sample)
    );

    // sum_reg doubles as the stage-1 sum: it only moves on an input transfer,
    // which is taken only when stage 1 is free or advancing
    assign sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(s_sample);

    alapm_peak u_peak (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (in_xfer),
        .sample       (s_sample),
        .last         (s_window_last),
        .reject_level (reject_reg),
        .peak         (peak)
    );

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_peak_reg <= peak;
        end
    end

    alapm_avg #(
        .DEPTH (DEPTH),
        .SUM_W (SUM_W)
    ) u_avg (
        .sum     (sum_reg),
        .average (avg)
    );

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_average_reg <= avg;
            m_peak_reg    <= s1_peak_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_average      = m_average_reg;
    assign m_peak_to_peak = m_peak_reg.p2p;
    assign m_window_done  = m_peak_reg.done;
    assign m_window_empty = m_peak_reg.empty;

    `ASSERT_IMPL(a_stall_blocks_input, aclk, aresetn,
                 s1_valid_reg && m_valid_reg && !m_ready, !s_ready)
    `ASSERT_IMPL(a_sum_bound, aclk, aresetn, 1'b1, sum_reg <= SUM_MAX)
    `ASSERT_IMPL(a_open_window_quiet, aclk, aresetn, m_valid && !m_window_done,
                 m_peak_to_peak == '0 && !m_window_empty)

endmodule
